@@ rtl/rational_bound_reducer_unit_defines.svh @@
// Assertion macros shared by the rational bound reducer RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef RATIONAL_BOUND_REDUCER_UNIT_DEFINES_SVH
`define RATIONAL_BOUND_REDUCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rbr_pkg.sv @@
// Package for the rational bound reducer: result kind codes, the control
// state type and the command struct passed to the limit tracker. No dependencies.
`timescale 1ns / 1ps

package rbr_pkg;

  // Result kind codes on the output channel.
  localparam logic [1:0] KIND_FINITE  = 2'd0;
  localparam logic [1:0] KIND_NEG_INF = 2'd1;
  localparam logic [1:0] KIND_POS_INF = 2'd2;

  // Code held in the decided register while no infinity has been fixed.
  localparam logic [1:0] DECIDED_NONE = 2'd0;

  // Register word indexes on the configuration port.
  localparam logic REG_SEEK_LOWER = 1'b0;
  localparam logic REG_DEN_POS    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_DONE  = 4'b1000
  } rbr_state_t;

  // Command from the sequencer to the limit tracker.
  typedef struct packed {
    logic apply;
    logic clear;
    logic lower_mode;
    logic den_zero;
    logic den_pos;
    logic num_neg;
    logic num_pos;
  } rbr_cmd_t;

endpackage

@@ rtl/rbr_divider.sv @@
// Bit-serial signed divider: (num << FRAC_BITS) / den, truncated and saturated.
// Uses no package items; instantiated by the top level.
`timescale 1ns / 1ps

module rbr_divider #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic signed [DATA_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quo
);

  localparam int STEPS = DATA_WIDTH + FRAC_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam logic [DATA_WIDTH-1:0] POS_LIM = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                  busy_r;
  logic                  pend_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [STEPS-1:0]      sr_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] q_r;
  logic [DATA_WIDTH-1:0] dmag_r;
  logic                  neg_r;
  logic                  over_r;
  logic [DATA_WIDTH-1:0] quo_r;

  logic [DATA_WIDTH-1:0] nmag;
  logic [DATA_WIDTH-1:0] dmag;
  logic [DATA_WIDTH-1:0] rem_sh;
  logic                  ge;
  logic [DATA_WIDTH-1:0] rem_nxt;
  logic [DATA_WIDTH-1:0] q_nxt;
  logic [DATA_WIDTH-1:0] limit;
  logic [DATA_WIDTH-1:0] mag;

  always_comb begin
    nmag    = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
    dmag    = den[DATA_WIDTH-1] ? (~den + 1'b1) : den;
    // The remainder stays below the divisor magnitude, so its top bit is free.
    rem_sh  = {rem_r[DATA_WIDTH-2:0], sr_r[STEPS-1]};
    ge      = (rem_sh >= dmag_r);
    rem_nxt = ge ? (rem_sh - dmag_r) : rem_sh;
    q_nxt   = {q_r[DATA_WIDTH-2:0], ge};
    limit   = neg_r ? NEG_LIM : POS_LIM;
    mag     = (over_r || (q_r > limit)) ? limit : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          pend_r <= 1'b1;
        end
      end else if (pend_r) begin
        pend_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr_r   <= STEPS'(nmag) << FRAC_BITS;
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
      dmag_r <= dmag;
      neg_r  <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
    end else if (busy_r) begin
      sr_r   <= sr_r << 1;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      // A set bit pushed out of the quotient register means it has overflowed.
      over_r <= over_r | q_r[DATA_WIDTH-1];
    end else if (pend_r) begin
      quo_r <= neg_r ? (~mag + 1'b1) : mag;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ rtl/rbr_tracker.sv @@
// Running upper and lower ratio limits, the decided infinity and the end-of-set
// result. Depends on rbr_pkg for the command struct and the kind codes.
`timescale 1ns / 1ps

module rbr_tracker import rbr_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rbr_cmd_t                     cmd,
  input  logic signed [DATA_WIDTH-1:0] quo,
  output logic                         decided,
  output logic signed [DATA_WIDTH-1:0] res_value,
  output logic [1:0]                   res_kind
);

  logic signed [DATA_WIDTH-1:0] upper_r;
  logic                         upper_inf_r;
  logic signed [DATA_WIDTH-1:0] lower_r;
  logic                         lower_inf_r;
  logic [1:0]                   decided_r;
  logic                         crossed;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      upper_r     <= '0;
      upper_inf_r <= 1'b1;
      lower_r     <= '0;
      lower_inf_r <= 1'b1;
      decided_r   <= DECIDED_NONE;
    end else if (cmd.apply && (decided_r == DECIDED_NONE)) begin
      if (cmd.den_zero) begin
        if (cmd.lower_mode && cmd.num_neg) begin
          decided_r <= KIND_NEG_INF;
        end else if (!cmd.lower_mode && cmd.num_pos) begin
          decided_r <= KIND_POS_INF;
        end
      end else if (cmd.den_pos == cmd.lower_mode) begin
        if (upper_inf_r || (quo < upper_r)) begin
          upper_r <= quo;
        end
        upper_inf_r <= 1'b0;
      end else begin
        if (lower_inf_r || (quo > lower_r)) begin
          lower_r <= quo;
        end
        lower_inf_r <= 1'b0;
      end
    end
  end

  always_comb begin
    crossed   = !upper_inf_r && !lower_inf_r && (lower_r > upper_r);
    res_value = '0;
    res_kind  = decided_r;
    if (decided_r == DECIDED_NONE) begin
      if (crossed) begin
        res_kind = cmd.lower_mode ? KIND_NEG_INF : KIND_POS_INF;
      end else if (cmd.lower_mode) begin
        if (upper_inf_r) begin
          res_kind = KIND_POS_INF;
        end else begin
          res_kind  = KIND_FINITE;
          res_value = upper_r;
        end
      end else begin
        if (lower_inf_r) begin
          res_kind = KIND_NEG_INF;
        end else begin
          res_kind  = KIND_FINITE;
          res_value = lower_r;
        end
      end
    end
  end

  assign decided = (decided_r != DECIDED_NONE);

endmodule

@@ rtl/rational_bound_reducer_unit.sv @@
// Top level of the rational bound reducer: channels, configuration registers,
// sequencer and result register. Depends on rbr_pkg, rbr_divider, rbr_tracker.
//
//   Channel  Direction  Handshake              Beat payload
//   in_      input      in_valid / in_stall    num_value, den_value, last_pair
//   out_     output     out_valid / out_stall  bound_value, bound_kind
//   cfg_     input      APB write, pready=1    seek_lower, denominators_positive
//
// A pair with a nonzero denominator goes through the bit-serial divider, which
// retires one quotient bit per cycle, and then the apply state. A pair with a
// zero denominator, or one arriving after the answer is already fixed at an
// infinity, skips the divider. A final pair then loads the result register in
// the done state. Reset is synchronous and active low. A result waiting under
// out_stall does not block new input beats; only a further final pair waits
// until the result register is free.
`timescale 1ns / 1ps
`include "rational_bound_reducer_unit_defines.svh"

module rational_bound_reducer_unit import rbr_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_num_value,
  input  logic signed [DATA_WIDTH-1:0] in_den_value,
  input  logic                         in_last_pair,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_bound_value,
  output logic [1:0]                   out_bound_kind,
  // Configuration port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [2:0]                   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  rbr_state_t state_r, state_nxt;

  // Configuration registers.
  logic seek_lower_r;
  logic den_pos_cfg_r;

  // Captured beat.
  logic signed [DATA_WIDTH-1:0] num_r;
  logic                         den_zero_r;
  logic                         den_neg_r;
  logic                         last_r;
  logic                         lower_r;

  // Result register.
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_value_r;
  logic [1:0]                   out_kind_r;

  logic                         in_accept;
  logic                         cfg_write;
  logic                         lower_mode;
  logic                         den_zero;
  logic                         div_start;
  logic                         div_done;
  logic signed [DATA_WIDTH-1:0] div_quo;
  logic                         decided;
  logic signed [DATA_WIDTH-1:0] res_value;
  logic [1:0]                   res_kind;
  logic                         out_load;
  logic                         out_inf;
  rbr_cmd_t                     cmd;

  // ---------------------------------------------------------------------------
  // Configuration port. The word index is taken from address bit 2, so the two
  // registers sit at byte addresses 0 and 4.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seek_lower_r  <= 1'b1;
      den_pos_cfg_r <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_paddr[2] == REG_SEEK_LOWER) begin
        seek_lower_r <= cfg_pwdata[0];
      end else begin
        den_pos_cfg_r <= cfg_pwdata[0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_DEN_POS) begin
      cfg_prdata = {31'd0, den_pos_cfg_r};
    end else begin
      cfg_prdata = {31'd0, seek_lower_r};
    end
  end

  // A negative denominator setting flips the direction of the bound.
  assign lower_mode = seek_lower_r ^ ~den_pos_cfg_r;

  // ---------------------------------------------------------------------------
  // Sequencer. A beat is taken only in idle. The divider is skipped when the
  // denominator is zero or when an infinity has already been fixed for the set;
  // the beat is still consumed so that its last_pair flag is honored.
  // ---------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign den_zero  = (in_den_value == '0);
  assign div_start = in_accept && !den_zero && !decided;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = div_start ? ST_DIV : ST_APPLY;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_nxt = last_r ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The mode is captured with the beat, so the tracker sees the mode that was
  // current when the pair arrived.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      num_r      <= in_num_value;
      den_zero_r <= den_zero;
      den_neg_r  <= in_den_value[DATA_WIDTH-1];
      last_r     <= in_last_pair;
      lower_r    <= lower_mode;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.apply      = (state_r == ST_APPLY);
    cmd.clear      = out_load;
    cmd.lower_mode = lower_r;
    cmd.den_zero   = den_zero_r;
    cmd.den_pos    = !den_neg_r;
    cmd.num_neg    = num_r[DATA_WIDTH-1];
    cmd.num_pos    = !num_r[DATA_WIDTH-1] && (num_r != '0);
  end

  rbr_divider #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (in_num_value),
    .den   (in_den_value),
    .done  (div_done),
    .quo   (div_quo)
  );

  rbr_tracker #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .quo       (div_quo),
    .decided   (decided),
    .res_value (res_value),
    .res_kind  (res_kind)
  );

  // ---------------------------------------------------------------------------
  // Result register. It is loaded at the end of a set, and the tracker is
  // cleared in the same cycle, ready for the next set.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= res_value;
      out_kind_r  <= res_kind;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bound_value = out_value_r;
  assign out_bound_kind  = out_kind_r;

  // An infinite result on the output carries a zero value.
  assign out_inf = out_valid_r && (out_kind_r != KIND_FINITE);

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `RBR_ASSERT_IMPL(a_div_done_in_div, div_done, state_r == ST_DIV, "done outside ST_DIV")
  `RBR_ASSERT_IMPL(a_inf_value_zero, out_inf, out_value_r == '0, "nonzero infinite bound")
  `RBR_ASSERT_NEXT(a_out_drains, out_valid_r && !out_stall && !out_load, !out_valid_r, "beat repeated")

endmodule

@@ dv/rbr_bound_checker.sv @@
// Scoreboard for the rational bound reducer: follows the register writes, predicts
// the bound of each set from the accepted pair beats and compares every result beat.
// Depends on rbr_pkg for the result kind codes and register indexes.
`timescale 1ns / 1ps

module rbr_bound_checker import rbr_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_num_value,
  input  logic signed [DATA_WIDTH-1:0] in_den_value,
  input  logic                         in_last_pair,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [DATA_WIDTH-1:0] out_bound_value,
  input  logic [1:0]                   out_bound_kind,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [2:0]                   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  input  logic                         cfg_pready,
  output int                           fail_count,
  output int                           pending_count
);

  typedef logic signed [DATA_WIDTH-1:0] fix_t;

  typedef struct packed {
    fix_t       value;
    logic [1:0] kind;
  } bound_t;

  bound_t     bounds_q[$];
  logic       seek_lower   = 1'b1;
  logic       den_positive = 1'b1;
  fix_t       upper_lim    = '0;
  fix_t       lower_lim    = '0;
  logic       upper_inf    = 1'b1;
  logic       lower_inf    = 1'b1;
  logic [1:0] decided      = DECIDED_NONE;
  int         fails        = 0;

  // Truncated (num << FRAC_BITS) / den, clamped to the signed data range.
  function automatic fix_t sat_quotient(fix_t num, fix_t den);
    longint scaled, q, top, bottom;
    top    = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    bottom = -top - 1;
    scaled = longint'(num) <<< FRAC_BITS;
    q      = scaled / longint'(den);
    if (q > top) begin
      q = top;
    end else if (q < bottom) begin
      q = bottom;
    end
    return fix_t'(q);
  endfunction

  task automatic clear_set();
    upper_lim = '0;
    upper_inf = 1'b1;
    lower_lim = '0;
    lower_inf = 1'b1;
    decided   = DECIDED_NONE;
  endtask

  task automatic absorb_pair(fix_t num, fix_t den, logic last);
    logic   lower_mode;
    fix_t   q;
    bound_t b;
    lower_mode = seek_lower ^ ~den_positive;
    if (decided == DECIDED_NONE) begin
      if (den == '0) begin
        if (lower_mode && num < 0) begin
          decided = KIND_NEG_INF;
        end else if (!lower_mode && num > 0) begin
          decided = KIND_POS_INF;
        end
      end else begin
        q = sat_quotient(num, den);
        if ((den > 0) == lower_mode) begin
          if (upper_inf || q < upper_lim) upper_lim = q;
          upper_inf = 1'b0;
        end else begin
          if (lower_inf || q > lower_lim) lower_lim = q;
          lower_inf = 1'b0;
        end
      end
    end
    if (last) begin
      b.value = '0;
      b.kind  = KIND_FINITE;
      if (decided != DECIDED_NONE) begin
        b.kind = decided;
      end else if (!upper_inf && !lower_inf && lower_lim > upper_lim) begin
        b.kind = lower_mode ? KIND_NEG_INF : KIND_POS_INF;
      end else if (lower_mode) begin
        if (upper_inf) b.kind = KIND_POS_INF;
        else b.value = upper_lim;
      end else begin
        if (lower_inf) b.kind = KIND_NEG_INF;
        else b.value = lower_lim;
      end
      bounds_q = {bounds_q, b};
      clear_set();
    end
  endtask

  always @(posedge clk) begin
    bound_t want;
    if (!rst_n) begin
      seek_lower   = 1'b1;
      den_positive = 1'b1;
      clear_set();
      bounds_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (bounds_q.size() == 0) begin
          fails++;
          $error("bound beat with no set pending: bound_value %0d bound_kind %0d",
                 out_bound_value, out_bound_kind);
        end else begin
          want = bounds_q.pop_front();
          if (out_bound_value !== want.value) begin
            fails++;
            $error("bound_value: expected %0d, got %0d", want.value, out_bound_value);
          end
          if (out_bound_kind !== want.kind) begin
            fails++;
            $error("bound_kind: expected %0d, got %0d", want.kind, out_bound_kind);
          end
        end
      end
      if (in_valid && !in_stall) begin
        absorb_pair(in_num_value, in_den_value, in_last_pair);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_SEEK_LOWER) begin
          seek_lower = cfg_pwdata[0];
        end else if (cfg_paddr[2] == REG_DEN_POS) begin
          den_positive = cfg_pwdata[0];
        end
      end
    end
    fail_count    <= fails;
    pending_count <= bounds_q.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the rational bound reducer bench: clock, reset, pair and register stimulus,
// result-side backpressure and the verdict. Depends on rbr_pkg, the block and rbr_bound_checker.
`timescale 1ns / 1ps

module testbench;
  import rbr_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;

  // Q16.16 constants used by the directed sets.
  localparam logic [DW-1:0] ONE     = 32'h0001_0000;
  localparam logic [DW-1:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [DW-1:0] MAXV    = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] MINV    = 32'h8000_0000;
  localparam logic [DW-1:0] ALL_SET = 32'hFFFF_FFFF;

  // Cycles to let a pair still inside the divider finish, used before any
  // register write and at the very end.
  localparam int SETTLE_CYCLES = 64;
  // The receiver holds off this long once, so that a second final pair backs up.
  localparam int HOLD_CYCLES   = 3000;
  localparam int HOLD_AFTER    = 30;
  // Cycles without any beat or register access before the run is declared hung.
  localparam int STUCK_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 326;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [DW-1:0] in_num_value;
  logic signed [DW-1:0] in_den_value;
  logic                 in_last_pair;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [DW-1:0] out_bound_value;
  logic [1:0]           out_bound_kind;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [2:0]           cfg_paddr;
  logic [31:0]          cfg_pwdata;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  int fail_count;
  int pending_count;
  int items_sent  = 0;
  int beats_taken = 0;
  int stuck       = 0;
  bit steady      = 1'b0;

  always #2 clk = ~clk;

  rational_bound_reducer_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_num_value   (in_num_value),
    .in_den_value   (in_den_value),
    .in_last_pair   (in_last_pair),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bound_value(out_bound_value),
    .out_bound_kind (out_bound_kind),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  rbr_bound_checker #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_num_value   (in_num_value),
    .in_den_value   (in_den_value),
    .in_last_pair   (in_last_pair),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bound_value(out_bound_value),
    .out_bound_kind (out_bound_kind),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  // Idle stretch length shared by both sides: mostly none or short, rarely long.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Operand mix: corner values, full-range words that may saturate, and small
  // magnitudes (within plus or minus 8.0) whose quotients mostly stay in range and cross.
  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: return MINV;
          1: return MAXV;
          2: return '0;
          3: return 32'h0000_0001;
          4: return ALL_SET;
          5: return ONE;
          default: return NEG_ONE;
        endcase
      end
      1, 2: return $urandom;
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  // Zero denominators are common enough to hit both infinities in every mode.
  function automatic logic [DW-1:0] pick_den();
    if ($urandom_range(0, 7) == 0) return '0;
    return pick_value();
  endfunction

  // Offers one pair beat and returns at the edge where it is taken. Valid stays
  // high on return, so a caller that goes quiet must lower it first.
  task automatic send_pair(input logic [DW-1:0] num, input logic [DW-1:0] den,
                           input logic last);
    int gap;
    gap = steady ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_num_value <= num;
    in_den_value <= den;
    in_last_pair <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // One set of random length; some sets go out back to back with no gaps.
  task automatic send_set();
    int len, r;
    r = $urandom_range(0, 9);
    if (r < 6) len = $urandom_range(1, 3);
    else if (r < 9) len = $urandom_range(4, 8);
    else len = $urandom_range(9, 16);
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      send_pair(pick_value(), pick_den(), i == len - 1);
    end
    steady = 1'b0;
  endtask

  // Lets every expected bound come out, then lets a pair that is still being
  // divided (one that ends no set) finish before anything else happens.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase. Upper data bits are random
  // since the block must ignore them.
  task automatic write_reg(input logic idx, input logic bit_value);
    logic [31:0] data;
    data        = $urandom;
    data[0]     = bit_value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Pair and register stimulus, then the verdict.
  initial begin
    logic seek_plan[5];
    logic denpos_plan[5];
    int   target;
    seek_plan   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    denpos_plan = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_num_value <= '0;
    in_den_value <= '0;
    in_last_pair <= 1'b0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets in the reset mode, which seeks a lower bound.
    send_pair(ONE, ONE, 1'b1);
    // Quotients far past the data range saturate at either end.
    send_pair(MAXV, 32'h0000_0001, 1'b1);
    send_pair(MINV, 32'h0000_0001, 1'b1);
    // A negative denominator feeds the lower limit, which ends above the upper one.
    send_pair(MINV, ALL_SET, 1'b0);
    send_pair(ONE, ONE, 1'b1);
    // Zero denominators with a harmless numerator leave the upper limit infinite.
    send_pair('0, '0, 1'b0);
    send_pair(ONE, '0, 1'b1);
    // A negative numerator over zero fixes minus infinity; later pairs change nothing.
    send_pair(NEG_ONE, '0, 1'b0);
    send_pair(ONE, ONE, 1'b0);
    send_pair(MINV, '0, 1'b1);
    // Crossing limits built from small fractions.
    send_pair(32'h0003_0000, 32'h0002_0000, 1'b0);
    send_pair(NEG_ONE, 32'h0003_0000, 1'b0);
    send_pair(ONE, 32'hFFFC_0000, 1'b1);
    // Truncation toward zero of a negative quotient.
    send_pair(32'hFFFF_FFF9, 32'h0000_0003, 1'b1);
    send_pair(MAXV, MAXV, 1'b1);
    send_pair(MINV, MINV, 1'b1);
    send_pair('0, MINV, 1'b1);

    // The mode changes in the middle of a set: each pair keeps the mode it saw.
    send_pair(ONE, ONE, 1'b0);
    settle();
    write_reg(REG_SEEK_LOWER, 1'b0);
    send_pair(32'h0002_0000, ONE, 1'b1);
    settle();
    write_reg(REG_SEEK_LOWER, 1'b1);

    // Random sets under every mode, with the reset mode again at the end.
    for (int p = 0; p < 5; p++) begin
      settle();
      write_reg(REG_SEEK_LOWER, seek_plan[p]);
      write_reg(REG_DEN_POS, denpos_plan[p]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_set();
    end

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) beats_taken <= beats_taken + 1;
  end

  // Result side: random stall runs and open stretches, plus one long hold-off
  // while the sender keeps offering pairs, so that the block fills and stalls.
  initial begin
    bit held;
    int run;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && beats_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        run = pause_len();
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(50, 300);
      repeat (run) @(posedge clk);
    end
  end

  // Hang detection: any beat or register access restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
